FILE: rtl/fia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fia_pkg
// Shared types, codes and helpers of the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package fia_pkg;

    // conversion kinds (tuser[2:0])
    localparam logic [2:0] K_SDEC = 3'd0;
    localparam logic [2:0] K_UDEC = 3'd1;
    localparam logic [2:0] K_OCT  = 3'd2;
    localparam logic [2:0] K_HXL  = 3'd3;
    localparam logic [2:0] K_HXU  = 3'd4;

    localparam int VAL_W     = 64;
    localparam int NDIG      = 22;             // digit slots, octal needs all
    localparam int BUF_W     = 4 * NDIG;       // 88
    localparam int NBCD      = 20;             // decimal digits of 2^64-1
    localparam int BCD_W     = 4 * NBCD;       // 80
    localparam int CNT_W     = 5;
    localparam int STEP_W    = 5;              // 32 steps of two bits
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VAL_W / 2 - 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_PFX,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;       // capture input transfer
        logic dab;        // one double-dabble step (two bits)
        logic skip;       // drop a leading zero digit
        logic emit_pfx;   // push one prefix char to output
        logic emit_dig;   // push top digit to output
    } t_cmd;

    typedef struct packed {
        logic is_dec;
        logic dab_last;
        logic top_zero;
        logic cnt_one;
        logic pcnt_zero;
        logic out_free;
    } t_stat;

    // digit value to ASCII, lower or upper case letters
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] off;
        if (d < 4'd10) begin
            off = 8'h30;
        end else if (upper) begin
            off = 8'h37;
        end else begin
            off = 8'h57;
        end
        return {4'd0, d} + off;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fia_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fia_ctrl
// Sequencer: load, decimal conversion, zero skip, prefix, digit emission.
// ----------------------------------------------------------------------------
module fia_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire fia_pkg::t_stat i_stat,
    output fia_pkg::t_cmd       o_cmd
);

    fia_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fia_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fia_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = fia_pkg::ST_CONV;
            end
            fia_pkg::ST_CONV: begin
                if (!i_stat.is_dec || i_stat.dab_last) n_state = fia_pkg::ST_SKIP;
            end
            fia_pkg::ST_SKIP: begin
                if (!i_stat.top_zero || i_stat.cnt_one) n_state = fia_pkg::ST_PFX;
            end
            fia_pkg::ST_PFX: begin
                if (i_stat.pcnt_zero) n_state = fia_pkg::ST_EMIT;
            end
            fia_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.cnt_one) n_state = fia_pkg::ST_IDLE;
            end
            default: n_state = fia_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            fia_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            fia_pkg::ST_CONV: o_cmd.dab = i_stat.is_dec;
            fia_pkg::ST_SKIP: o_cmd.skip = i_stat.top_zero && !i_stat.cnt_one;
            fia_pkg::ST_PFX:  o_cmd.emit_pfx = !i_stat.pcnt_zero && i_stat.out_free;
            fia_pkg::ST_EMIT: o_cmd.emit_dig = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/fia_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fia_dp
// Datapath: magnitude, BCD shift-add-3 converter, digit buffer, prefix
// queue and output register.
// ----------------------------------------------------------------------------
module fia_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fia_pkg::t_cmd                 i_cmd,
    output fia_pkg::t_stat                     o_stat,
    input  wire logic [fia_pkg::VAL_W-1:0]     i_value,
    input  wire logic [2:0]                    i_kind,
    input  wire logic                          i_alt_form,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic [7:0]                         o_m_tdata,
    output logic                               o_m_tlast
);

    // one shift-add-3 bit step over the BCD digits
    function automatic logic [fia_pkg::BCD_W-1:0] dabble(
        input logic [fia_pkg::BCD_W-1:0] bcd, input logic bin_in);
        logic [fia_pkg::BCD_W-1:0] adj;
        logic [3:0]                d;
        for (int i = 0; i < fia_pkg::NBCD; i++) begin
            d = bcd[4*i +: 4];
            adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        return {adj[fia_pkg::BCD_W-2:0], bin_in};
    endfunction

    logic [fia_pkg::VAL_W-1:0]  r_bin,  n_bin;
    logic [fia_pkg::BUF_W-1:0]  r_buf,  n_buf;
    logic [fia_pkg::CNT_W-1:0]  r_cnt,  n_cnt;
    logic [15:0]                r_pfx,  n_pfx;
    logic [1:0]                 r_pcnt, n_pcnt;
    logic [fia_pkg::STEP_W-1:0] r_step, n_step;
    logic                       r_dec,  n_dec;
    logic                       r_up,   n_up;
    logic                       r_ov,   n_ov;
    logic [7:0]                 r_od,   n_od;
    logic                       r_ol,   n_ol;

    logic [fia_pkg::VAL_W-1:0]  w_mag;
    logic [fia_pkg::VAL_W+1:0]  w_v66;
    logic [fia_pkg::BUF_W-1:0]  w_oct;
    logic [fia_pkg::BCD_W-1:0]  w_bcd1, w_bcd2;
    logic                       w_nz, w_free;

    assign w_nz   = |i_value;
    assign w_mag  = (i_kind == fia_pkg::K_SDEC && i_value[fia_pkg::VAL_W-1])
                    ? (~i_value + 64'd1) : i_value;
    assign w_v66  = {2'b00, i_value};
    assign w_free = !r_ov || i_m_tready;

    always_comb begin
        for (int i = 0; i < fia_pkg::NDIG; i++) begin
            w_oct[4*i +: 4] = {1'b0, w_v66[3*i +: 3]};
        end
    end

    // two bits per step; BCD sits in the top 20 digit slots
    assign w_bcd1 = dabble(r_buf[fia_pkg::BUF_W-1 -: fia_pkg::BCD_W], r_bin[fia_pkg::VAL_W-1]);
    assign w_bcd2 = dabble(w_bcd1, r_bin[fia_pkg::VAL_W-2]);

    always_comb begin
        n_bin  = r_bin;
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        n_pfx  = r_pfx;
        n_pcnt = r_pcnt;
        n_step = r_step;
        n_dec  = r_dec;
        n_up   = r_up;
        n_ov   = r_ov && !i_m_tready;
        n_od   = r_od;
        n_ol   = r_ol;

        if (i_cmd.load) begin
            n_bin  = w_mag;
            n_step = '0;
            n_up   = (i_kind == fia_pkg::K_HXU);
            n_pfx  = '0;
            n_pcnt = 2'd0;
            case (i_kind) inside
                fia_pkg::K_OCT: begin
                    n_dec = 1'b0;
                    n_buf = w_oct;
                    n_cnt = fia_pkg::CNT_W'(fia_pkg::NDIG);
                    if (i_alt_form && w_nz) begin
                        n_pfx  = {8'h00, fia_pkg::CH_ZERO};
                        n_pcnt = 2'd1;
                    end
                end
                fia_pkg::K_HXL, fia_pkg::K_HXU: begin
                    n_dec = 1'b0;
                    n_buf = {i_value, {(fia_pkg::BUF_W - fia_pkg::VAL_W){1'b0}}};
                    n_cnt = fia_pkg::CNT_W'(fia_pkg::VAL_W / 4);
                    if (i_alt_form && w_nz) begin
                        n_pfx  = {fia_pkg::CH_X, fia_pkg::CH_ZERO};
                        n_pcnt = 2'd2;
                    end
                end
                default: begin
                    n_dec = 1'b1;
                    n_buf = '0;
                    n_cnt = fia_pkg::CNT_W'(fia_pkg::NBCD);
                    if (i_kind == fia_pkg::K_SDEC && i_value[fia_pkg::VAL_W-1]) begin
                        n_pfx  = {8'h00, fia_pkg::CH_MINUS};
                        n_pcnt = 2'd1;
                    end
                end
            endcase
        end else if (i_cmd.dab) begin
            n_buf  = {w_bcd2, {(fia_pkg::BUF_W - fia_pkg::BCD_W){1'b0}}};
            n_bin  = {r_bin[fia_pkg::VAL_W-3:0], 2'b00};
            n_step = r_step + 1'b1;
        end else if (i_cmd.skip) begin
            n_buf = {r_buf[fia_pkg::BUF_W-5:0], 4'h0};
            n_cnt = r_cnt - 1'b1;
        end else if (i_cmd.emit_pfx) begin
            n_ov   = 1'b1;
            n_od   = r_pfx[7:0];
            n_ol   = 1'b0;
            n_pfx  = {8'h00, r_pfx[15:8]};
            n_pcnt = r_pcnt - 1'b1;
        end else if (i_cmd.emit_dig) begin
            n_ov  = 1'b1;
            n_od  = fia_pkg::digit_char(r_buf[fia_pkg::BUF_W-1 -: 4], r_up);
            n_ol  = (r_cnt == fia_pkg::CNT_W'(1));
            n_buf = {r_buf[fia_pkg::BUF_W-5:0], 4'h0};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_buf  <= n_buf;
        r_cnt  <= n_cnt;
        r_pfx  <= n_pfx;
        r_pcnt <= n_pcnt;
        r_step <= n_step;
        r_dec  <= n_dec;
        r_up   <= n_up;
        r_od   <= n_od;
        r_ol   <= n_ol;
    end

    assign o_stat.is_dec    = r_dec;
    assign o_stat.dab_last  = (r_step == fia_pkg::STEP_LAST);
    assign o_stat.top_zero  = (r_buf[fia_pkg::BUF_W-1 -: 4] == 4'h0);
    assign o_stat.cnt_one   = (r_cnt == fia_pkg::CNT_W'(1));
    assign o_stat.pcnt_zero = (r_pcnt == 2'd0);
    assign o_stat.out_free  = w_free;

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tlast  = r_ol;

endmodule
`default_nettype wire

FILE: rtl/format_integer_to_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// format_integer_to_ascii
// Prints a 64-bit integer as an ASCII character stream, most significant
// digit first, in signed/unsigned decimal, octal or hex.
// ----------------------------------------------------------------------------
// One number is taken per input transfer; the block then drops tready until
// the last character of that number has been placed in the output register.
// Characters leave one per transfer with tlast on the final one. Steps per
// number: load, then for decimal a shift-add-3 BCD converter that folds two
// value bits per cycle (octal and hex pass straight through), then the drop
// of leading zero digits (up to 21), then the prefix characters (minus sign,
// "0" or "0x"), then the digits; prefix and digit characters wait while the
// output register is full and not taken. The next number is accepted in the
// cycle after the last character is loaded, while that character may still
// sit in the output register. Kinds 5..7 print as unsigned decimal. The
// alternate form adds "0" before octal and "0x" before hex, never for zero.
// ----------------------------------------------------------------------------
module format_integer_to_ascii (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // [63:0] value
    input  wire logic [3:0]  i_s_tuser,   // [2:0] kind, [3] alt_form
    // character stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] char_out
    output logic             o_m_tlast    // last char of the number
);

    fia_pkg::t_cmd  w_cmd;
    fia_pkg::t_stat w_stat;

    // sequencer: issues at most one datapath command per cycle
    fia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // converter, digit buffer and output register
    fia_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_value    (i_s_tdata),
        .i_kind     (i_s_tuser[2:0]),
        .i_alt_form (i_s_tuser[3]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

FILE: rtl/fia_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fia_chk
// Port-level checks of the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
module fia_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata,
    input wire logic        o_m_tlast
);

    logic w_in_xfer, w_out_xfer, w_legal;

    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_xfer = o_m_tvalid && i_m_tready;
    assign w_legal = (o_m_tdata >= 8'h30 && o_m_tdata <= 8'h39)
                  || (o_m_tdata >= 8'h41 && o_m_tdata <= 8'h46)
                  || (o_m_tdata >= 8'h61 && o_m_tdata <= 8'h66)
                  || o_m_tdata == 8'h2d || o_m_tdata == 8'h78;

    // stalled character holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output changed");

    // block goes busy after taking a number
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_s_tready)
        else $error("ready stayed high after input transfer");

    // ready returns only together with the final character
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_s_tready) |-> o_m_tvalid && o_m_tlast)
        else $error("ready returned without final character");

    // only digits, letters a-f/A-F, minus or x appear
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_legal)
        else $error("illegal character");

    // minus sign and x are never last
    a_pfx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer && (o_m_tdata == 8'h2d || o_m_tdata == 8'h78) |-> !o_m_tlast)
        else $error("prefix char marked last");

endmodule

bind format_integer_to_ascii fia_chk u_fia_chk (.*);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer-to-ASCII formatter. A directed table of
// numbers (extremes, every kind, the alternate form and the unused kinds) is
// sent first, then random numbers under three sender/receiver idle profiles.
// Every character transfer is compared against an independent printf-style
// formatter kept in the bench, or against the typed text of a table row.
// ----------------------------------------------------------------------------
module tb_top;
    import fia_pkg::*;

    // kinds the package leaves unnamed; the block prints them as unsigned decimal
    localparam logic [2:0] K_UNUSED5 = 3'd5;
    localparam logic [2:0] K_UNUSED6 = 3'd6;
    localparam logic [2:0] K_UNUSED7 = 3'd7;

    localparam int N_RANDOM    = 346;
    localparam int DRAIN_WAIT  = 64;        // longer than one full decimal number
    localparam int CYCLE_LIMIT = 400000;

    // one expected character transfer
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    // one directed number; empty text means the formatter below predicts it
    typedef struct {
        logic [63:0] value;
        logic [2:0]  kind;
        logic        alt;
        string       text;
    } t_number;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [63:0] i_s_tdata  = '0;
    logic [3:0]  i_s_tuser  = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    t_char   expected_chars[$];
    t_number number_table[$];
    int      fail_count  = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 8;
    int      recv_idle_pct = 49;

    format_integer_to_ascii i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // [63:0] value
        .i_s_tuser  (i_s_tuser),    // [2:0] kind, [3] alt_form
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // [7:0] char_out
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Independent printf-style formatter: appends the characters of one
    // number to the expectation queue, last flag on the final one.
    function automatic void push_printed_number(input logic [63:0] value,
                                                input logic [2:0] kind,
                                                input logic alt);
        logic [63:0] mag;
        logic [63:0] radix;
        logic        upper;
        logic [3:0]  digit;
        logic [7:0]  line[$];
        logic [7:0]  rev[$];
        mag   = value;
        radix = 64'd10;
        upper = 1'b0;
        case (kind)
            K_SDEC: begin
                if (value[63]) begin
                    line.push_back("-");
                    mag = -value;       // true magnitude, also for the minimum
                end
            end
            K_OCT: begin
                radix = 64'd8;
                if (alt && value != 0) line.push_back("0");
            end
            K_HXL, K_HXU: begin
                radix = 64'd16;
                upper = (kind == K_HXU);
                if (alt && value != 0) begin
                    line.push_back("0");
                    line.push_back("x");
                end
            end
            default: ;                  // unsigned decimal, flag ignored
        endcase
        do begin
            digit = 4'(mag % radix);
            mag   = mag / radix;
            if (digit < 4'd10) begin
                rev.push_front(8'({4'd0, digit}) + "0");
            end else if (upper) begin
                rev.push_front(8'({4'd0, digit}) - 8'd10 + "A");
            end else begin
                rev.push_front(8'({4'd0, digit}) - 8'd10 + "a");
            end
        end while (mag != 0);
        foreach (rev[i]) line.push_back(rev[i]);
        foreach (line[i]) expected_chars.push_back('{line[i], i == line.size() - 1});
    endfunction

    function automatic void add_number(input logic [63:0] value, input logic [2:0] kind,
                                       input logic alt, input string text);
        t_number row;
        row.value = value;
        row.kind  = kind;
        row.alt   = alt;
        row.text  = text;
        number_table.push_back(row);
    endfunction

    // Random value spread over lengths, edges and radix boundaries.
    function automatic logic [63:0] pick_value();
        logic [63:0] p;
        int          k;
        p = 64'd1;
        k = $urandom_range(0, 19);
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 300));
            2: return {$urandom, $urandom} >> $urandom_range(0, 63);
            3: begin
                case ($urandom_range(0, 3))
                    0: return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 2));
                    1: return 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 2));
                    2: return '1 - 64'($urandom_range(0, 2));
                    default: return 64'(1) << $urandom_range(0, 63);
                endcase
            end
            4: begin
                // around powers of ten: digit count changes here
                repeat (k) p = p * 64'd10;
                return p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: return -64'($urandom_range(1, 1000));
        endcase
    endfunction

    // Send one number, idling in front at random; returns at the accepting edge
    // without touching tvalid, so the caller's next drive is the only one.
    task automatic send_number(input logic [63:0] value, input logic [2:0] kind,
                               input logic alt, input string text);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= {alt, kind};
        // inputs and tready are stable at the falling edge
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        if (text.len() == 0) begin
            push_printed_number(value, kind, alt);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                expected_chars.push_back('{8'(text[i]), i == text.len() - 1});
            end
        end
    endtask

    // Receiver back-pressure, one drive per rising edge.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Character checker: a transfer happens at the next rising edge when both
    // handshake signals are high at the falling edge.
    always @(negedge i_clk) begin
        t_char want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character transfer: char_out %h last %b",
                       o_m_tdata, o_m_tlast);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_m_tdata !== want.ch) begin
                    $error("char_out mismatch: expected %h got %h", want.ch, o_m_tdata);
                    fail_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last mismatch: expected %b got %b", want.last, o_m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [63:0] value;
        logic [2:0]  kind;
        int          pick;

        // directed table: zero, extremes, every kind, prefix rules, unused kinds
        add_number(64'd0,                  K_SDEC,    1'b0, "0");
        add_number(64'd0,                  K_HXL,     1'b1, "0");
        add_number(64'd0,                  K_OCT,     1'b1, "0");
        add_number(64'h8000_0000_0000_0000, K_SDEC,   1'b0, "-9223372036854775808");
        add_number(64'h7fff_ffff_ffff_ffff, K_SDEC,   1'b1, "9223372036854775807");
        add_number('1,                     K_SDEC,    1'b0, "-1");
        add_number('1,                     K_UDEC,    1'b1, "18446744073709551615");
        add_number('1,                     K_OCT,     1'b1, "01777777777777777777777");
        add_number('1,                     K_OCT,     1'b0, "1777777777777777777777");
        add_number('1,                     K_HXL,     1'b1, "0xffffffffffffffff");
        add_number('1,                     K_HXU,     1'b0, "FFFFFFFFFFFFFFFF");
        add_number(64'h0123_4567_89ab_cdef, K_HXL,    1'b1, "0x123456789abcdef");
        add_number(64'h0123_4567_89ab_cdef, K_HXU,    1'b0, "123456789ABCDEF");
        add_number(64'd8,                  K_OCT,     1'b1, "010");
        add_number(64'd1,                  K_OCT,     1'b0, "1");
        add_number(64'd123,                K_SDEC,    1'b1, "123");
        add_number(64'd255,                K_UDEC,    1'b1, "255");
        add_number(64'd42,                 K_UNUSED5, 1'b1, "42");
        add_number(64'd0,                  K_UNUSED6, 1'b1, "0");
        add_number('1,                     K_UNUSED7, 1'b1, "18446744073709551615");
        add_number(64'hfedc_ba98_7654_3210, K_SDEC,   1'b0, "");
        add_number(64'h5555_5555_5555_5555, K_OCT,    1'b1, "");
        add_number(64'haaaa_aaaa_aaaa_aaaa, K_UDEC,   1'b0, "");
        add_number(64'hdead_beef_cafe_f00d, K_HXU,    1'b1, "");
        add_number(64'd10_000_000_000_000_000_000, K_UDEC, 1'b0, "");

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (number_table[i]) begin
            send_number(number_table[i].value, number_table[i].kind,
                        number_table[i].alt, number_table[i].text);
        end

        // random part: sender idles lightly, then heavily, then never
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 49;
                recv_idle_pct = 8;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            value = pick_value();
            pick  = $urandom_range(0, 11);
            kind  = (pick < 10) ? 3'(pick / 2) : 3'($urandom_range(5, 7));
            send_number(value, kind, 1'($urandom_range(0, 1)), "");
        end
        i_s_tvalid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
